// ===== rtl/core/sdgd_pkg.sv =====
// Package with the shared types and constants of the sensor dropout gap detector.
`default_nettype none
package sdgd_pkg;

    localparam int NUM_SENSORS = 16;
    localparam int SENS_W      = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 22;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_GAP  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_JUMP_THR = CFG_ADDR_W'(1);

    localparam logic [15:0] MIN_GAP_RESET  = 16'd2;
    localparam logic [21:0] JUMP_THR_RESET = 22'd20000;
    localparam logic [15:0] CNT_MAX        = 16'hFFFF;

    typedef struct packed {
        logic               window_start;
        logic [3:0]         sensor_index;
        logic               reading_valid;
        logic [21:0]        distance_um;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic [62:0]        time_ns;
    } t_in_item;

    typedef struct packed {
        logic [62:0]        event_time_ns;
        logic [3:0]         event_sensor;
        logic signed [23:0] before_x;
        logic signed [23:0] before_y;
        logic signed [23:0] before_z;
        logic signed [23:0] after_x;
        logic signed [23:0] after_y;
        logic signed [23:0] after_z;
        logic [21:0]        distance_before;
        logic [21:0]        distance_after;
        logic [15:0]        gap_length;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic                  we;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage
`default_nettype wire

// ===== rtl/core/sensor_dropout_gap_detector.sv =====
// Top level of the sensor dropout gap detector.
//
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   i_in_data (t_in_item)
// out      output     o_out_valid / i_out_stall o_out_data (t_out_item)
// cfg      input      i_cfg_we                  i_cfg_addr, i_cfg_data
//
// One reading is taken per cycle while the queue is not full; the reading behind an event passes
// through the queue and the event then through the output register. The per-sensor state is read,
// updated and written back in the same cycle, which sets the rate. Reset is synchronous and clears
// the queue, the output and the per-sensor valid bits, so no clearing pass is needed. A stalled
// output holds its event while the queue keeps taking readings until it is full.
`default_nettype none
module sensor_dropout_gap_detector (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  sdgd_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output sdgd_pkg::t_out_item                  o_out_data,
    input  wire                                  i_cfg_we,
    input  wire [sdgd_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire [sdgd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import sdgd_pkg::*;

    t_q_status q_status;
    logic      push;
    t_in_item  push_data;
    logic      pop;
    t_in_item  head;
    t_cfg_wr   cfg;

    assign cfg.we   = i_cfg_we;
    assign cfg.addr = i_cfg_addr;
    assign cfg.data = i_cfg_data;

    sdgd_front u_front (
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    sdgd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    sdgd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_status  (q_status),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== rtl/core/sdgd_front.sv =====
// Front end: accepts readings, drops those of unknown sensors and pushes the rest.
`default_nettype none
module sdgd_front (
    input  wire                 i_in_valid,
    input  sdgd_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    input  sdgd_pkg::t_q_status i_q_status,
    output logic                o_push,
    output sdgd_pkg::t_in_item  o_push_data
);
    import sdgd_pkg::*;

    logic in_range;

    assign in_range    = 32'(i_in_data.sensor_index) < 32'(NUM_SENSORS);
    assign o_in_stall  = i_q_status.full;
    assign o_push      = i_in_valid && !i_q_status.full && in_range;
    assign o_push_data = i_in_data;

endmodule
`default_nettype wire

// ===== rtl/core/sdgd_queue.sv =====
// Short queue between the front end and the per-sensor back end.
`default_nettype none
module sdgd_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  sdgd_pkg::t_in_item  i_push_data,
    input  wire                 i_pop,
    output sdgd_pkg::t_in_item  o_head,
    output sdgd_pkg::t_q_status o_status
);
    import sdgd_pkg::*;

    t_in_item           r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_PTR_W-1:0] n_wr_ptr;
    logic [Q_PTR_W-1:0] n_rd_ptr;
    logic [Q_CNT_W-1:0] n_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = r_count == Q_CNT_W'(Q_DEPTH);
    assign o_status.empty = r_count == '0;
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sdgd_back.sv =====
// Back end: per-sensor state table, gap decision and the output register.
`default_nettype none
module sdgd_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  sdgd_pkg::t_cfg_wr   i_cfg,
    input  sdgd_pkg::t_q_status i_q_status,
    input  sdgd_pkg::t_in_item  i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output sdgd_pkg::t_out_item o_out_data
);
    import sdgd_pkg::*;

    logic [15:0]        r_min_gap;
    logic [21:0]        r_jump_thr;

    logic [NUM_SENSORS-1:0] r_ent_vld;
    logic               r_gap  [NUM_SENSORS];
    logic [15:0]        r_cnt  [NUM_SENSORS];
    logic [21:0]        r_dist [NUM_SENSORS];
    logic signed [23:0] r_px   [NUM_SENSORS];
    logic signed [23:0] r_py   [NUM_SENSORS];
    logic signed [23:0] r_pz   [NUM_SENSORS];

    logic               r_out_valid;
    t_out_item          r_out_data;

    logic [SENS_W-1:0]  idx;
    logic               cur_ok;
    logic               cur_gap;
    logic [15:0]        cur_cnt;
    logic [21:0]        cur_dist;
    logic signed [23:0] cur_px;
    logic signed [23:0] cur_py;
    logic signed [23:0] cur_pz;
    logic [21:0]        diff;
    logic               go;
    logic               emit;
    logic               n_gap;
    logic [15:0]        n_cnt;
    logic [21:0]        n_dist;
    logic signed [23:0] n_px;
    logic signed [23:0] n_py;
    logic signed [23:0] n_pz;
    t_out_item          evt;

    assign idx      = SENS_W'(i_head.sensor_index);
    assign cur_ok   = r_ent_vld[idx] && !i_head.window_start;
    assign cur_gap  = cur_ok ? r_gap[idx] : 1'b0;
    assign cur_cnt  = cur_ok ? r_cnt[idx] : '0;
    assign cur_dist = cur_ok ? r_dist[idx] : '0;
    assign cur_px   = cur_ok ? r_px[idx] : '0;
    assign cur_py   = cur_ok ? r_py[idx] : '0;
    assign cur_pz   = cur_ok ? r_pz[idx] : '0;

    assign diff = (cur_dist > i_head.distance_um) ? cur_dist - i_head.distance_um
                                                  : i_head.distance_um - cur_dist;
    assign go   = !i_q_status.empty && (!r_out_valid || !i_out_stall);
    assign o_pop = go;

    always_comb begin
        emit   = 1'b0;
        n_gap  = cur_gap;
        n_cnt  = cur_cnt;
        n_dist = cur_dist;
        n_px   = cur_px;
        n_py   = cur_py;
        n_pz   = cur_pz;
        if (!i_head.reading_valid) begin
            n_gap = 1'b1;
            if (!cur_gap) begin
                n_cnt = 16'd1;
            end else if (cur_cnt != CNT_MAX) begin
                n_cnt = cur_cnt + 16'd1;
            end
        end else begin
            if (cur_gap) begin
                emit  = (cur_cnt >= r_min_gap) && (diff > r_jump_thr);
                n_gap = 1'b0;
                n_cnt = '0;
            end
            n_dist = i_head.distance_um;
            n_px   = i_head.pos_x;
            n_py   = i_head.pos_y;
            n_pz   = i_head.pos_z;
        end
    end

    always_comb begin
        evt.event_time_ns   = i_head.time_ns;
        evt.event_sensor    = i_head.sensor_index;
        evt.before_x        = cur_px;
        evt.before_y        = cur_py;
        evt.before_z        = cur_pz;
        evt.after_x         = i_head.pos_x;
        evt.after_y         = i_head.pos_y;
        evt.after_z         = i_head.pos_z;
        evt.distance_before = cur_dist;
        evt.distance_after  = i_head.distance_um;
        evt.gap_length      = cur_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap  <= MIN_GAP_RESET;
            r_jump_thr <= JUMP_THR_RESET;
        end else if (i_cfg.we) begin
            case (i_cfg.addr)
                REG_MIN_GAP:  r_min_gap  <= i_cfg.data[15:0];
                REG_JUMP_THR: r_jump_thr <= i_cfg.data[21:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (go) begin
            r_ent_vld[idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_gap[idx]  <= n_gap;
            r_cnt[idx]  <= n_cnt;
            r_dist[idx] <= n_dist;
            r_px[idx]   <= n_px;
            r_py[idx]   <= n_py;
            r_pz[idx]   <= n_pz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            r_out_data <= evt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// ===== rtl/core/sdgd_checker.sv =====
// Port-level assertions for the sensor dropout gap detector and their bind.
`default_nettype none
module sdgd_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  i_in_valid,
    input wire                                  o_in_stall,
    input sdgd_pkg::t_in_item                   i_in_data,
    input wire                                  o_out_valid,
    input wire                                  i_out_stall,
    input sdgd_pkg::t_out_item                  o_out_data,
    input wire                                  i_cfg_we,
    input wire [sdgd_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input wire [sdgd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import sdgd_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled transaction changed");

    a_gap_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.gap_length != 16'd0)
        else $error("event with empty gap");

    a_distance_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.distance_before != o_out_data.distance_after)
        else $error("event without distance change");

    a_sensor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_data.event_sensor) < 32'(NUM_SENSORS))
        else $error("event from unknown sensor");

endmodule

bind sensor_dropout_gap_detector sdgd_checker u_sdgd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_addr  (i_cfg_addr),
    .i_cfg_data  (i_cfg_data)
);
`default_nettype wire

// ===== tb/sdgd_gap_checker.sv =====
// Checker that predicts the gap events of the sensor dropout gap detector and compares them.
`default_nettype none
module sdgd_gap_checker (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    input  wire                                  i_in_stall,
    input  sdgd_pkg::t_in_item                   i_in_data,
    input  wire                                  i_out_valid,
    input  wire                                  i_out_stall,
    input  sdgd_pkg::t_out_item                  i_out_data,
    input  wire                                  i_cfg_we,
    input  wire [sdgd_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire [sdgd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output int                                   o_mismatches,
    output int                                   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import sdgd_pkg::*;

    logic [15:0]        min_gap;
    logic [21:0]        jump_thr;
    logic               gap_open [NUM_SENSORS];
    logic [15:0]        run_len  [NUM_SENSORS];
    logic [21:0]        held_dist[NUM_SENSORS];
    logic signed [23:0] held_x   [NUM_SENSORS];
    logic signed [23:0] held_y   [NUM_SENSORS];
    logic signed [23:0] held_z   [NUM_SENSORS];
    t_out_item          expected_events[$];
    int                 mismatch_count = 0;

    task automatic forget_sensor(input int s);
        gap_open[s]  = 1'b0;
        run_len[s]   = '0;
        held_dist[s] = '0;
        held_x[s]    = '0;
        held_y[s]    = '0;
        held_z[s]    = '0;
    endtask

    task automatic apply_reading(input t_in_item r);
        int          s;
        logic [21:0] diff;
        t_out_item   ev;
        s = r.sensor_index;
        if (s >= NUM_SENSORS) return;
        if (r.window_start) forget_sensor(s);
        if (!r.reading_valid) begin
            if (!gap_open[s]) begin
                gap_open[s] = 1'b1;
                run_len[s]  = 16'd1;
            end else if (run_len[s] != CNT_MAX) begin
                run_len[s] = run_len[s] + 16'd1;
            end
            return;
        end
        if (gap_open[s]) begin
            diff = (held_dist[s] > r.distance_um) ? held_dist[s] - r.distance_um
                                                  : r.distance_um - held_dist[s];
            gap_open[s] = 1'b0;
            if (run_len[s] >= min_gap && diff > jump_thr) begin
                ev.event_time_ns   = r.time_ns;
                ev.event_sensor    = r.sensor_index;
                ev.before_x        = held_x[s];
                ev.before_y        = held_y[s];
                ev.before_z        = held_z[s];
                ev.after_x         = r.pos_x;
                ev.after_y         = r.pos_y;
                ev.after_z         = r.pos_z;
                ev.distance_before = held_dist[s];
                ev.distance_after  = r.distance_um;
                ev.gap_length      = run_len[s];
                expected_events.insert(expected_events.size(), ev);
            end
            run_len[s] = '0;
        end
        held_dist[s] = r.distance_um;
        held_x[s]    = r.pos_x;
        held_y[s]    = r.pos_y;
        held_z[s]    = r.pos_z;
    endtask

    task automatic check_event(input t_out_item got);
        t_out_item want;
        if (expected_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] unexpected gap event: %p", $realtime, got);
            return;
        end
        want = expected_events.pop_front();
        if (got.event_time_ns !== want.event_time_ns || got.event_sensor !== want.event_sensor ||
            got.before_x !== want.before_x || got.before_y !== want.before_y ||
            got.before_z !== want.before_z || got.after_x !== want.after_x ||
            got.after_y !== want.after_y || got.after_z !== want.after_z ||
            got.distance_before !== want.distance_before ||
            got.distance_after !== want.distance_after ||
            got.gap_length !== want.gap_length) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("[%0t] gap event mismatch", $realtime);
                $display("  expected: %p", want);
                $display("  actual:   %p", got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            min_gap  = MIN_GAP_RESET;
            jump_thr = JUMP_THR_RESET;
            for (int s = 0; s < NUM_SENSORS; s++) forget_sensor(s);
            expected_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MIN_GAP: begin
                        min_gap = i_cfg_data[15:0];
                    end
                    REG_JUMP_THR: begin
                        jump_thr = i_cfg_data[21:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) apply_reading(i_in_data);
            if (i_out_valid && !i_out_stall) check_event(i_out_data);
        end
        o_outstanding <= expected_events.size();
        o_mismatches  <= mismatch_count;
    end

endmodule
`default_nettype wire

// ===== tb/sensor_dropout_gap_detector_test.sv =====
// Testbench top that drives readings and configuration into the gap detector and gives the verdict.
`default_nettype none
module sensor_dropout_gap_detector_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sdgd_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 5000;
    localparam int DIST_TOP     = 4194303;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    int cur_min = int'(MIN_GAP_RESET);
    int cur_thr = int'(JUMP_THR_RESET);
    int last_sent[NUM_SENSORS];
    int gap_plan [NUM_SENSORS];

    always #6 clk = ~clk;

    sensor_dropout_gap_detector dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    sdgd_gap_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 35);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in_item reading(input bit ws, input int s, input bit v, input int d);
        t_in_item r;
        r.window_start  = ws;
        r.sensor_index  = s[3:0];
        r.reading_valid = v;
        r.distance_um   = d[21:0];
        r.pos_x         = 24'($urandom);
        r.pos_y         = 24'($urandom);
        r.pos_z         = 24'($urandom);
        r.time_ns       = 63'({$urandom, $urandom});
        return r;
    endfunction

    task automatic send_reading(input t_in_item r);
        while (!quiet && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (r.window_start) last_sent[r.sensor_index] = 0;
        if (r.reading_valid) last_sent[r.sensor_index] = r.distance_um;
    endtask

    // Waits until every predicted event has come out and the pipeline has emptied.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input int min_len, input int thr);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_MIN_GAP;
        cfg_data <= {6'($urandom), min_len[15:0]};
        @(posedge clk);
        cfg_addr <= REG_JUMP_THR;
        cfg_data <= thr[21:0];
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_min = min_len;
        cur_thr = thr;
    endtask

    task automatic directed_readings();
        t_in_item r;
        send_reading(reading(1, 0, 1, 0));
        r = reading(0, 15, 1, DIST_TOP);
        r.pos_x   = 24'sh7FFFFF;
        r.pos_y   = 24'sh800000;
        r.pos_z   = -24'sd1;
        r.time_ns = '1;
        send_reading(r);
        repeat (2) send_reading(reading(0, 15, 0, $urandom));
        r = reading(0, 15, 1, 0);
        r.pos_x = 24'sh800000;
        r.pos_y = 24'sh7FFFFF;
        r.pos_z = '0;
        send_reading(r);
        send_reading(reading(0, 0, 0, $urandom));
        send_reading(reading(0, 0, 1, 3000000));
        send_reading(reading(1, 5, 0, $urandom));
        send_reading(reading(0, 5, 0, $urandom));
        send_reading(reading(0, 5, 1, 30000));
        send_reading(reading(0, 7, 1, 100000));
        repeat (2) send_reading(reading(0, 7, 0, $urandom));
        send_reading(reading(1, 7, 1, 500000));
        send_reading(reading(0, 3, 1, 100000));
        repeat (2) send_reading(reading(0, 3, 0, $urandom));
        send_reading(reading(0, 3, 1, 120000));
        repeat (2) send_reading(reading(0, 3, 0, $urandom));
        send_reading(reading(0, 3, 1, 140001));
        send_reading(reading(0, 3, 1, 140001));
    endtask

    task automatic random_readings(input int count);
        t_in_item r;
        int       s;
        int       hot_base;
        int       pick;
        longint   tgt;
        hot_base = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0) hot_base = $urandom_range(15);
            if (i % 200 == 0) quiet = (i == 200) || ($urandom_range(3) == 0);
            s = ($urandom_range(99) < 85) ? (hot_base + $urandom_range(2)) % NUM_SENSORS
                                          : $urandom_range(NUM_SENSORS - 1);
            r = reading(1'($urandom_range(1)), s, 1'($urandom_range(1)), $urandom);
            if ($urandom_range(99) >= 8) begin
                r.window_start = 1'b0;
                if (gap_plan[s] > 0) begin
                    r.reading_valid = 1'b0;
                    gap_plan[s]--;
                end else begin
                    r.reading_valid = 1'b1;
                    pick = $urandom_range(9);
                    tgt  = -1;
                    if (pick >= 6)
                        tgt = last_sent[s] + ((pick % 2) ? 1 : -1) * (cur_thr + (pick >= 8));
                    else if (pick >= 4)
                        tgt = last_sent[s] + int'($urandom_range(2000)) - 1000;
                    if (tgt >= 0 && tgt <= DIST_TOP) r.distance_um = tgt[21:0];
                    gap_plan[s] = ($urandom_range(9) == 0) ? $urandom_range(12)
                                                           : $urandom_range(cur_min + 2);
                end
            end
            send_reading(r);
        end
        quiet = 1'b0;
    endtask

    initial begin
        for (int s = 0; s < NUM_SENSORS; s++) begin
            last_sent[s] = 0;
            gap_plan[s]  = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_readings();
        settle();
        set_config(1, 0);
        random_readings(300);
        settle();
        set_config(0, DIST_TOP);
        random_readings(120);
        settle();
        set_config(3, $urandom_range(1000, 100000));
        random_readings(300);
        settle();
        set_config(2, 20000);
        random_readings(330);
        settle();

        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
